// ===== hdl/mrf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU request framer package
// Shared constants, types and the byte-wide CRC-16/MODBUS update function.
// ----------------------------------------------------------------------------
package mrf_pkg;

    localparam logic [7:0]  FUNC_READ      = 8'd3;
    localparam logic [7:0]  FUNC_WRITE     = 8'd6;
    localparam logic [7:0]  DEV_ADDR_RESET = 8'd1;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;

    localparam logic [2:0] POS_DEV_ADDR = 3'd0;
    localparam logic [2:0] POS_FUNC     = 3'd1;
    localparam logic [2:0] POS_ADDR_HI  = 3'd2;
    localparam logic [2:0] POS_ADDR_LO  = 3'd3;
    localparam logic [2:0] POS_VAL_HI   = 3'd4;
    localparam logic [2:0] POS_VAL_LO   = 3'd5;
    localparam logic [2:0] POS_CRC_LO   = 3'd6;
    localparam logic [2:0] POS_CRC_HI   = 3'd7;

    typedef struct packed {
        logic       init;
        logic       update;
        logic [7:0] data;
    } t_crc_ctrl;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ===== hdl/mrf_crc16.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU CRC accumulator
// Running CRC-16/MODBUS; folds in one byte per cycle while update is set.
// ----------------------------------------------------------------------------
module mrf_crc16
    import mrf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_crc_ctrl   i_ctrl,
    output logic [15:0] o_crc
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    always_comb begin
        n_crc = r_crc;
        if (i_ctrl.init) begin
            n_crc = CRC_INIT;
        end else if (i_ctrl.update) begin
            n_crc = crc_byte(r_crc, i_ctrl.data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

// ===== hdl/mrf_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU frame sequencer
// Captures a request, walks the eight frame positions and registers each byte.
// ----------------------------------------------------------------------------
module mrf_seq
    import mrf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_dev_addr,
    input  logic        i_action,
    input  logic [15:0] i_reg_address,
    input  logic [15:0] i_reg_value,
    input  logic [15:0] i_crc,
    output t_crc_ctrl   o_crc_ctrl,
    output logic        o_strobe,
    output logic [7:0]  o_frame_byte,
    output logic        o_last_byte
);

    logic        r_active;
    logic [2:0]  r_pos;
    logic [7:0]  r_dev_addr;
    logic        r_action;
    logic [15:0] r_address;
    logic [15:0] r_value;
    logic        r_strobe;
    logic [7:0]  r_byte;
    logic        r_last;

    logic        n_active;
    logic [2:0]  n_pos;
    logic        accept;
    logic [7:0]  cur_byte;

    assign busy   = r_active && (r_pos != POS_CRC_HI);
    assign accept = start && !busy;

    always_comb begin
        unique case (r_pos)
            POS_DEV_ADDR: cur_byte = r_dev_addr;
            POS_FUNC:     cur_byte = r_action ? FUNC_WRITE : FUNC_READ;
            POS_ADDR_HI:  cur_byte = r_address[15:8];
            POS_ADDR_LO:  cur_byte = r_address[7:0];
            POS_VAL_HI:   cur_byte = r_value[15:8];
            POS_VAL_LO:   cur_byte = r_value[7:0];
            POS_CRC_LO:   cur_byte = i_crc[7:0];
            POS_CRC_HI:   cur_byte = i_crc[15:8];
            default:      cur_byte = r_dev_addr;
        endcase
    end

    always_comb begin
        o_crc_ctrl.init   = accept;
        o_crc_ctrl.update = r_active && (r_pos < POS_CRC_LO);
        o_crc_ctrl.data   = cur_byte;
    end

    always_comb begin
        n_active = r_active;
        n_pos    = r_pos;
        if (accept) begin
            n_active = 1'b1;
            n_pos    = POS_DEV_ADDR;
        end else if (r_active) begin
            if (r_pos == POS_CRC_HI) begin
                n_active = 1'b0;
            end
            n_pos = r_pos + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= POS_DEV_ADDR;
            r_strobe <= 1'b0;
        end else begin
            r_active <= n_active;
            r_pos    <= n_pos;
            r_strobe <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dev_addr <= i_dev_addr;
            r_action   <= i_action;
            r_address  <= i_reg_address;
            r_value    <= i_reg_value;
        end
        r_byte <= cur_byte;
        r_last <= r_active && (r_pos == POS_CRC_HI);
    end

    assign o_strobe     = r_strobe;
    assign o_frame_byte = r_byte;
    assign o_last_byte  = r_last && r_strobe;

endmodule

// ===== hdl/modbus_rtu_request_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU request framer
// Turns a read-holding-register or write-single-register request into the
// eight-byte RTU frame with its CRC-16/MODBUS, one byte per cycle.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Once the request is
// registered in the sequencer and its first byte in the output register, the
// frame appears as eight bytes on consecutive o_strobe cycles, with
// o_last_byte on the CRC high byte; the receiver cannot stall them. Busy drops
// in the cycle in which the CRC low byte is on the output, so that a following
// request streams out right after the CRC high byte without a gap. The CRC is
// accumulated one byte per cycle as the header bytes are registered for
// output. The device address register resets to 1 and is written through the
// configuration channel, which is always ready.
module modbus_rtu_request_framer
    import mrf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [15:0] i_reg_address,
    input  logic [15:0] i_reg_value,
    output logic        o_strobe,
    output logic [7:0]  o_frame_byte,
    output logic        o_last_byte
);

    logic [7:0]  r_dev_addr;
    logic [15:0] crc;
    t_crc_ctrl   crc_ctrl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dev_addr <= i_cfg_data;
        end
    end

    mrf_crc16 u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (crc_ctrl),
        .o_crc   (crc)
    );

    mrf_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_dev_addr    (r_dev_addr),
        .i_action      (i_action),
        .i_reg_address (i_reg_address),
        .i_reg_value   (i_reg_value),
        .i_crc         (crc),
        .o_crc_ctrl    (crc_ctrl),
        .o_strobe      (o_strobe),
        .o_frame_byte  (o_frame_byte),
        .o_last_byte   (o_last_byte)
    );

endmodule

// ===== hdl/mrf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU request framer checker
// Port-level timing checks on the request and byte channels.
// ----------------------------------------------------------------------------
module mrf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input logic o_last_byte
);

    // An accepted request raises busy in the next cycle and puts out its
    // first byte in the cycle after that.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after an accepted request");

    a_accept_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> ##1 o_strobe)
        else $error("frame did not start after an accepted request");

    // Bytes of one frame are contiguous.
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_byte |=> o_strobe)
        else $error("gap inside a frame");

    a_last_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_byte |-> o_strobe)
        else $error("last byte flag without strobe");

    a_last_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_byte |=> !o_last_byte)
        else $error("last byte flag on consecutive cycles");

endmodule

bind modbus_rtu_request_framer mrf_checker u_mrf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_last_byte (o_last_byte)
);
